// ----- rtl/nca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared widths, codes and types of the nearest centroid assignment block.
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int COORD_W       = 16;
  localparam int SQ_W          = 34;
  localparam int DIST_W        = 36;
  localparam int PID_W         = 16;
  localparam int CIDX_W        = 4;
  localparam int DIDX_W        = 4;
  localparam int CFG_W         = 5;
  localparam int CLUSTER_OUT_W = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic CFG_CLUSTER_COUNT = 1'b0;
  localparam logic CFG_DIM_COUNT     = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } stream_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
  } token_t;

endpackage

// ----- rtl/nca_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_if
// Valid/ready channels for coordinate items and classification results.
// ----------------------------------------------------------------------------
interface nca_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [nca_pkg::CIDX_W-1:0]       centroid_index;
  logic [nca_pkg::DIDX_W-1:0]       coord_index;
  logic signed [nca_pkg::COORD_W-1:0] coord_value;
  logic                             last_coord;
  logic [nca_pkg::PID_W-1:0]        point_id;

  modport source (output valid, cmd, centroid_index, coord_index, coord_value,
                  last_coord, point_id, input ready);
  modport sink (input valid, cmd, centroid_index, coord_index, coord_value,
                last_coord, point_id, output ready);
endinterface

interface nca_out_if;
  logic                              valid;
  logic                              ready;
  logic [nca_pkg::CLUSTER_OUT_W-1:0] nearest_cluster;
  logic [nca_pkg::DIST_W-1:0]        min_distance;
  logic [nca_pkg::PID_W-1:0]         result_point_id;

  modport source (output valid, nearest_cluster, min_distance, result_point_id,
                  input ready);
  modport sink (input valid, nearest_cluster, min_distance, result_point_id,
                output ready);
endinterface

// ----- rtl/nearest_centroid_assign.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// K-means assignment step: a row of centroid cells measures the squared
// distance of a buffered point and passes the running minimum along the row.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  items     in   valid/ready     cmd, centroid_index, coord_index,
//                                 coord_value, last_coord, point_id
//  results   out  valid/ready     nearest_cluster, min_distance, result_point_id
//  cfg       in   cfg_we          cfg_index, cfg_data
//
// Load items and point coordinates without the last flag are stored while the
// block stays idle. A last coordinate starts a pass of the point through the
// cell row; its result turns valid once the coordinates have streamed out of the
// point buffer and the running minimum has passed every cell of the row, and
// ready rises again together with the result valid. Ready stays low during the
// pass, and the pass waits while an earlier result is not taken.
// Reset is synchronous; the centroid and point stores are not cleared.
// ----------------------------------------------------------------------------
module nearest_centroid_assign #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nca_pkg::CFG_W-1:0]   cfg_data,
  nca_in_if.sink                      items,
  nca_out_if.source                   results
);

  localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KC_W = $clog2(MAX_CLUSTERS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [nca_pkg::CFG_W-1:0]   cluster_count;
  logic [nca_pkg::CFG_W-1:0]   dim_count;
  logic [KC_W-1:0]             kc;
  logic [6:0]                  dc;
  logic [DW-1:0]               dim_last;
  logic                        in_acc;
  logic                        pt_wr;
  logic                        cent_wr;
  logic                        start;
  logic [DW-1:0]               wr_addr;
  logic [nca_pkg::PID_W-1:0]   pid_q;
  logic                        res_valid;
  logic [KW-1:0]               res_idx;
  logic [nca_pkg::DIST_W-1:0]  res_dist;
  logic [nca_pkg::PID_W-1:0]   res_pid;

  nca_pkg::stream_ctrl_t ctrl_c [MAX_CLUSTERS+1];
  logic [DW-1:0]         dim_c  [MAX_CLUSTERS+1];
  nca_pkg::coord_t       val_c  [MAX_CLUSTERS+1];
  nca_pkg::token_t       tok_c  [MAX_CLUSTERS+1];
  logic [KW-1:0]         idx_c  [MAX_CLUSTERS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= nca_pkg::CFG_W'(1);
      dim_count     <= nca_pkg::CFG_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        nca_pkg::CFG_CLUSTER_COUNT: cluster_count <= cfg_data;
        nca_pkg::CFG_DIM_COUNT:     dim_count     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cluster_count == '0) begin
      kc = KC_W'(1);
    end else if (9'(cluster_count) > 9'(MAX_CLUSTERS)) begin
      kc = KC_W'(MAX_CLUSTERS);
    end else begin
      kc = KC_W'(cluster_count);
    end
    if (dim_count == '0) begin
      dc = 7'd1;
    end else if (7'(dim_count) > 7'(MAX_DIMS)) begin
      dc = 7'(MAX_DIMS);
    end else begin
      dc = 7'(dim_count);
    end
  end

  assign dim_last = DW'(dc - 7'd1);

  assign items.ready = (state == ST_IDLE);
  assign in_acc      = items.valid && items.ready;
  assign wr_addr     = DW'(items.coord_index);
  assign pt_wr       = in_acc && (items.cmd == nca_pkg::CMD_POINT)
                       && (7'(items.coord_index) < 7'(MAX_DIMS));
  assign cent_wr     = in_acc && (items.cmd == nca_pkg::CMD_LOAD)
                       && (9'(items.centroid_index) < 9'(MAX_CLUSTERS))
                       && (7'(items.coord_index) < 7'(MAX_DIMS));
  assign start       = (state == ST_WAIT) && !res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (items.cmd == nca_pkg::CMD_POINT) && items.last_coord) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!res_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (tok_c[MAX_CLUSTERS].valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (tok_c[MAX_CLUSTERS].valid) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pid_q <= items.point_id;
    end
    if (tok_c[MAX_CLUSTERS].valid) begin
      res_idx  <= idx_c[MAX_CLUSTERS];
      res_dist <= tok_c[MAX_CLUSTERS].distance;
      res_pid  <= pid_q;
    end
  end

  assign results.valid           = res_valid;
  assign results.nearest_cluster = nca_pkg::CLUSTER_OUT_W'(res_idx);
  assign results.min_distance    = res_dist;
  assign results.result_point_id = res_pid;

  nca_point_buf #(
    .MAX_DIMS (MAX_DIMS),
    .DW       (DW)
  ) u_point_buf (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (pt_wr),
    .wr_addr   (wr_addr),
    .wr_data   (items.coord_value),
    .start     (start),
    .dim_last  (dim_last),
    .out_ctrl  (ctrl_c[0]),
    .out_dim   (dim_c[0]),
    .out_value (val_c[0])
  );

  assign tok_c[0] = '0;
  assign idx_c[0] = '0;

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    nca_cell #(
      .MAX_DIMS (MAX_DIMS),
      .DW       (DW),
      .KW       (KW),
      .KC_W     (KC_W),
      .K        (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .kc          (kc),
      .wr_en       (cent_wr && (int'(items.centroid_index) == k)),
      .wr_addr     (wr_addr),
      .wr_data     (items.coord_value),
      .in_ctrl     (ctrl_c[k]),
      .in_dim      (dim_c[k]),
      .in_value    (val_c[k]),
      .out_ctrl    (ctrl_c[k+1]),
      .out_dim     (dim_c[k+1]),
      .out_value   (val_c[k+1]),
      .tok_in      (tok_c[k]),
      .tok_in_idx  (idx_c[k]),
      .tok_out     (tok_c[k+1]),
      .tok_out_idx (idx_c[k+1])
    );
  end

  // A finished distance only leaves the row during a pass, into an empty slot.
  a_final_in_run: assert property (@(posedge clk) disable iff (rst)
    tok_c[MAX_CLUSTERS].valid |-> (state == ST_RUN) && !res_valid)
    else $error("final transaction outside a pass or over a pending result");

  a_stream_in_run: assert property (@(posedge clk) disable iff (rst)
    ctrl_c[MAX_CLUSTERS].valid |-> (state == ST_RUN))
    else $error("coordinate stream alive outside a pass");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_RUN))
    else $error("result raised without a pass");

endmodule

// ----- rtl/nca_point_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_point_buf
// Point coordinate buffer that streams the stored point into the cell row.
// ----------------------------------------------------------------------------
module nca_point_buf #(
  parameter int MAX_DIMS = 16,
  parameter int DW       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [DW-1:0]         wr_addr,
  input  nca_pkg::coord_t       wr_data,
  input  logic                  start,
  input  logic [DW-1:0]         dim_last,
  output nca_pkg::stream_ctrl_t out_ctrl,
  output logic [DW-1:0]         out_dim,
  output nca_pkg::coord_t       out_value
);

  nca_pkg::coord_t mem [MAX_DIMS];
  logic            run;
  logic [DW-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    out_value <= mem[cnt];
    out_dim   <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      cnt      <= '0;
      out_ctrl <= '0;
    end else begin
      out_ctrl <= '{valid: run, first: (cnt == '0), last: (cnt == dim_last)};
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == dim_last) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/nca_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_cell
// One centroid: its coordinates, a squared distance accumulator and a
// compare stage on the running minimum passed along the row.
// ----------------------------------------------------------------------------
module nca_cell #(
  parameter int MAX_DIMS = 16,
  parameter int DW       = 4,
  parameter int KW       = 4,
  parameter int KC_W     = 5,
  parameter int K        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [KC_W-1:0]       kc,
  input  logic                  wr_en,
  input  logic [DW-1:0]         wr_addr,
  input  nca_pkg::coord_t       wr_data,
  input  nca_pkg::stream_ctrl_t in_ctrl,
  input  logic [DW-1:0]         in_dim,
  input  nca_pkg::coord_t       in_value,
  output nca_pkg::stream_ctrl_t out_ctrl,
  output logic [DW-1:0]         out_dim,
  output nca_pkg::coord_t       out_value,
  input  nca_pkg::token_t       tok_in,
  input  logic [KW-1:0]         tok_in_idx,
  output nca_pkg::token_t       tok_out,
  output logic [KW-1:0]         tok_out_idx
);

  nca_pkg::coord_t                  cent [MAX_DIMS];
  nca_pkg::coord_t                  cent_rd;
  nca_pkg::coord_t                  s1_pt;
  nca_pkg::stream_ctrl_t            s1_ctrl;
  nca_pkg::stream_ctrl_t            s2_ctrl;
  logic signed [nca_pkg::COORD_W:0] diff;
  logic [nca_pkg::COORD_W:0]        mag;
  logic [nca_pkg::SQ_W-1:0]         sq;
  logic [nca_pkg::DIST_W:0]         sum;
  logic [nca_pkg::DIST_W-1:0]       sat;
  logic [nca_pkg::DIST_W-1:0]       acc;
  logic                             done;
  logic                             active;
  logic                             take_own;
  logic                             tok_valid;
  logic [nca_pkg::DIST_W-1:0]       tok_dist;

  assign diff = {s1_pt[nca_pkg::COORD_W-1], s1_pt} - {cent_rd[nca_pkg::COORD_W-1], cent_rd};
  assign mag  = diff[nca_pkg::COORD_W] ? (nca_pkg::COORD_W+1)'(-diff)
                                       : (nca_pkg::COORD_W+1)'(diff);
  assign sum  = {1'b0, acc} + (nca_pkg::DIST_W+1)'(sq);
  assign sat  = (sum > {1'b0, nca_pkg::DIST_MAX}) ? nca_pkg::DIST_MAX
                                                  : sum[nca_pkg::DIST_W-1:0];

  assign active   = KC_W'(K) < kc;
  assign take_own = active && (!tok_in.valid || (acc < tok_in.distance));

  assign tok_out = '{valid: tok_valid, distance: tok_dist};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cent[wr_addr] <= wr_data;
    end
    cent_rd   <= cent[in_dim];
    s1_pt     <= in_value;
    sq        <= nca_pkg::SQ_W'(mag) * nca_pkg::SQ_W'(mag);
    out_dim   <= in_dim;
    out_value <= in_value;
    if (s2_ctrl.valid) begin
      acc <= s2_ctrl.first ? nca_pkg::DIST_W'(sq) : sat;
    end
    tok_dist    <= take_own ? acc : tok_in.distance;
    tok_out_idx <= take_own ? KW'(K) : tok_in_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl   <= '0;
      s2_ctrl   <= '0;
      out_ctrl  <= '0;
      done      <= 1'b0;
      tok_valid <= 1'b0;
    end else begin
      s1_ctrl   <= in_ctrl;
      s2_ctrl   <= s1_ctrl;
      out_ctrl  <= in_ctrl;
      done      <= s2_ctrl.valid && s2_ctrl.last;
      tok_valid <= done;
    end
  end

endmodule
